FILE: rtl/core/cks_pkg.sv
package cks_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int COORD_W       = 16;
  localparam int HANDLE_W      = 16;
  localparam int STATUS_W      = 3;
  localparam int SLOT_IDX_W    = 8;

  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_HANDLE = 3'd4;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic [COORD_W-1:0]  key_x;
    logic [COORD_W-1:0]  key_y;
    logic [COORD_W-1:0]  key_z;
    logic [HANDLE_W-1:0] handle;
  } slot_entry_t;

  typedef struct packed {
    logic                have_match;
    idx_t                match_idx;
    logic [HANDLE_W-1:0] match_handle;
    logic                have_free;
    idx_t                free_idx;
  } scan_res_t;

endpackage

FILE: rtl/core/coord_keyed_slot_table_core.sv
// Keyed slot table: a request is taken when start is high and busy is low, and
// its one result appears as a single-cycle out_valid strobe that the receiver
// cannot hold off. The result follows one pass over the slot memory, one slot
// per cycle through a single key comparator, which finds both the lowest
// matching slot and the lowest free slot; an insert is written in the done state
// after the pass and the drain state. busy is high from the accepted request until
// the strobe, and a new request may be given in the strobe cycle. Slot in-use bits
// clear at reset; no clearing pass is needed.
module coord_keyed_slot_table_core
  import cks_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_req_type,
  input  logic signed [COORD_W-1:0]    in_coord_x,
  input  logic signed [COORD_W-1:0]    in_coord_y,
  input  logic signed [COORD_W-1:0]    in_coord_z,
  input  logic        [HANDLE_W-1:0]   in_object_handle,
  input  logic                         in_handle_ok,
  output logic                         out_valid,
  output logic        [STATUS_W-1:0]   out_status,
  output logic        [SLOT_IDX_W-1:0] out_slot_index,
  output logic        [HANDLE_W-1:0]   out_slot_handle
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]               state_r, state_nxt;
  idx_t                     addr_r, addr_nxt;
  logic [TABLE_ENTRIES-1:0] used_r, used_nxt;

  logic                req_insert_r;
  logic [COORD_W-1:0]  req_x_r, req_y_r, req_z_r;
  logic [HANDLE_W-1:0] req_handle_r;
  logic                req_ok_r;

  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [SLOT_IDX_W-1:0] out_index_r, out_index_nxt;
  logic [HANDLE_W-1:0]   out_handle_r, out_handle_nxt;

  logic        accept;
  logic        rd_en;
  logic        wr_en;
  slot_entry_t wr_data;
  slot_entry_t rd_data;
  scan_res_t   scan_res;

  assign accept = start && (state_r == S_IDLE);
  assign rd_en  = (state_r == S_SCAN);

  cks_slot_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (scan_res.free_idx),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (addr_r),
    .rd_data (rd_data)
  );

  cks_scan_unit u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (accept),
    .rd_en   (rd_en),
    .rd_idx  (addr_r),
    .rd_used (used_r[addr_r]),
    .rd_data (rd_data),
    .req_x   (req_x_r),
    .req_y   (req_y_r),
    .req_z   (req_z_r),
    .res     (scan_res)
  );

  assign wr_data.key_x  = req_x_r;
  assign wr_data.key_y  = req_y_r;
  assign wr_data.key_z  = req_z_r;
  assign wr_data.handle = req_handle_r;

  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    used_nxt       = used_r;
    wr_en          = 1'b0;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_index_nxt  = out_index_r;
    out_handle_nxt = out_handle_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          addr_nxt  = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (addr_r == IDX_W'(TABLE_ENTRIES - 1)) begin
          state_nxt = S_DRAIN;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt      = S_IDLE;
        out_valid_nxt  = 1'b1;
        out_index_nxt  = '0;
        out_handle_nxt = '0;
        if (scan_res.have_match) begin
          out_status_nxt = ST_FOUND;
          out_index_nxt  = SLOT_IDX_W'(scan_res.match_idx);
          out_handle_nxt = scan_res.match_handle;
        end else if (!req_insert_r) begin
          out_status_nxt = ST_NOT_FOUND;
        end else if (!scan_res.have_free) begin
          out_status_nxt = ST_FULL;
        end else if (!req_ok_r) begin
          out_status_nxt = ST_NO_HANDLE;
        end else begin
          wr_en                       = 1'b1;
          used_nxt[scan_res.free_idx] = 1'b1;
          out_status_nxt              = ST_INSERTED;
          out_index_nxt               = SLOT_IDX_W'(scan_res.free_idx);
          out_handle_nxt              = req_handle_r;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r       <= addr_nxt;
    out_status_r <= out_status_nxt;
    out_index_r  <= out_index_nxt;
    out_handle_r <= out_handle_nxt;
    if (accept) begin
      req_insert_r <= in_req_type;
      req_x_r      <= in_coord_x;
      req_y_r      <= in_coord_y;
      req_z_r      <= in_coord_z;
      req_handle_r <= in_object_handle;
      req_ok_r     <= in_handle_ok;
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_slot_index  = out_index_r;
  assign out_slot_handle = out_handle_r;

endmodule

FILE: rtl/core/cks_slot_mem.sv
module cks_slot_mem
  import cks_pkg::*;
(
  input  logic        clk,
  input  logic        wr_en,
  input  idx_t        wr_addr,
  input  slot_entry_t wr_data,
  input  logic        rd_en,
  input  idx_t        rd_addr,
  output slot_entry_t rd_data
);

  slot_entry_t mem_r [TABLE_ENTRIES];
  slot_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/core/cks_scan_unit.sv
module cks_scan_unit
  import cks_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               clr,
  input  logic               rd_en,
  input  idx_t               rd_idx,
  input  logic               rd_used,
  input  slot_entry_t        rd_data,
  input  logic [COORD_W-1:0] req_x,
  input  logic [COORD_W-1:0] req_y,
  input  logic [COORD_W-1:0] req_z,
  output scan_res_t          res
);

  // read address and in-use bit are registered to line up with the memory's registered read
  logic      go_r;
  idx_t      idx_r;
  logic      used_r;
  scan_res_t res_r, res_nxt;
  logic      key_eq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      go_r <= 1'b0;
    end else begin
      go_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= rd_idx;
    used_r <= rd_used;
  end

  assign key_eq = (rd_data.key_x == req_x) && (rd_data.key_y == req_y) &&
                  (rd_data.key_z == req_z);

  always_comb begin
    res_nxt = res_r;
    if (clr) begin
      res_nxt.have_match = 1'b0;
      res_nxt.have_free  = 1'b0;
    end else if (go_r) begin
      if (used_r) begin
        if (!res_r.have_match && key_eq) begin
          res_nxt.have_match   = 1'b1;
          res_nxt.match_idx    = idx_r;
          res_nxt.match_handle = rd_data.handle;
        end
      end else if (!res_r.have_free) begin
        res_nxt.have_free = 1'b1;
        res_nxt.free_idx  = idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (!rst_n) begin
      res_r.have_match <= 1'b0;
      res_r.have_free  <= 1'b0;
    end
  end

  assign res = res_r;

endmodule

FILE: rtl/core/cks_checker.sv
module cks_checker
  import cks_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  out_valid,
  input logic [STATUS_W-1:0]   out_status,
  input logic [SLOT_IDX_W-1:0] out_slot_index,
  input logic [HANDLE_W-1:0]   out_slot_handle
);

  // a result ends the request: busy drops exactly when the strobe shows
  a_fall_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(busy) |-> out_valid)
    else $error("busy fell without a result");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("request taken but not busy");

  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_NOT_FOUND || out_status == ST_FULL ||
                  out_status == ST_NO_HANDLE)
    |-> out_slot_index == '0 && out_slot_handle == '0)
    else $error("failed request carries a slot");

endmodule

bind coord_keyed_slot_table_core cks_checker u_cks_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_slot_index  (out_slot_index),
  .out_slot_handle (out_slot_handle)
);

FILE: test/coord_keyed_slot_table_core_tb.sv
`timescale 1ns / 100ps

module coord_keyed_slot_table_core_tb;
  import cks_pkg::*;

  typedef struct {
    logic                      insert;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [HANDLE_W-1:0]       handle;
    logic                      ok;
  } req_t;

  typedef struct {
    logic [STATUS_W-1:0]   status;
    logic [SLOT_IDX_W-1:0] index;
    logic [HANDLE_W-1:0]   handle;
  } reply_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         start = 1'b0;
  logic                         busy;
  logic                         in_req_type = 1'b0;
  logic signed [COORD_W-1:0]    in_coord_x = '0;
  logic signed [COORD_W-1:0]    in_coord_y = '0;
  logic signed [COORD_W-1:0]    in_coord_z = '0;
  logic        [HANDLE_W-1:0]   in_object_handle = '0;
  logic                         in_handle_ok = 1'b0;
  logic                         out_valid;
  logic        [STATUS_W-1:0]   out_status;
  logic        [SLOT_IDX_W-1:0] out_slot_index;
  logic        [HANDLE_W-1:0]   out_slot_handle;

  coord_keyed_slot_table_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_coord_x       (in_coord_x),
    .in_coord_y       (in_coord_y),
    .in_coord_z       (in_coord_z),
    .in_object_handle (in_object_handle),
    .in_handle_ok     (in_handle_ok),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_slot_index   (out_slot_index),
    .out_slot_handle  (out_slot_handle)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the slot table
  bit                        slot_used [TABLE_ENTRIES];
  logic signed [COORD_W-1:0] slot_kx   [TABLE_ENTRIES];
  logic signed [COORD_W-1:0] slot_ky   [TABLE_ENTRIES];
  logic signed [COORD_W-1:0] slot_kz   [TABLE_ENTRIES];
  logic [HANDLE_W-1:0]       slot_obj  [TABLE_ENTRIES];

  req_t   req_q[$];
  req_t   key_pool[$];
  reply_t reply_q[$];
  req_t   cur_req;
  int     gap_left = 0;
  int     burst_left = 0;
  int     mismatches = 0;

  function automatic reply_t table_access(req_t r);
    reply_t rep;
    bit     hit;
    bit     hole;
    int     hit_i;
    int     hole_i;
    hit = 1'b0;
    hole = 1'b0;
    hit_i = 0;
    hole_i = 0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (slot_used[i]) begin
        if (!hit && slot_kx[i] == r.x && slot_ky[i] == r.y && slot_kz[i] == r.z) begin
          hit = 1'b1;
          hit_i = i;
        end
      end else if (!hole) begin
        hole = 1'b1;
        hole_i = i;
      end
    end
    rep.index = '0;
    rep.handle = '0;
    if (hit) begin
      rep.status = ST_FOUND;
      rep.index = SLOT_IDX_W'(hit_i);
      rep.handle = slot_obj[hit_i];
    end else if (!r.insert) begin
      rep.status = ST_NOT_FOUND;
    end else if (!hole) begin
      rep.status = ST_FULL;
    end else if (!r.ok) begin
      rep.status = ST_NO_HANDLE;
    end else begin
      slot_used[hole_i] = 1'b1;
      slot_kx[hole_i] = r.x;
      slot_ky[hole_i] = r.y;
      slot_kz[hole_i] = r.z;
      slot_obj[hole_i] = r.handle;
      rep.status = ST_INSERTED;
      rep.index = SLOT_IDX_W'(hole_i);
      rep.handle = r.handle;
    end
    return rep;
  endfunction

  // mostly short gaps, some spanning the scan, a few long; occasional bursts with none
  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 99) < 3) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 3);
    if (r < 95) return $urandom_range(4, 270);
    return $urandom_range(271, 600);
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord();
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0: return 16'h8000;
        1: return 16'h7FFF;
        2: return 16'h0000;
        default: return 16'hFFFF;
      endcase
    end
    return COORD_W'($urandom);
  endfunction

  task automatic add_req(input logic ins, input logic signed [COORD_W-1:0] x,
                         input logic signed [COORD_W-1:0] y,
                         input logic signed [COORD_W-1:0] z,
                         input logic [HANDLE_W-1:0] h, input logic ok);
    req_t r;
    r.insert = ins;
    r.x = x;
    r.y = y;
    r.z = z;
    r.handle = h;
    r.ok = ok;
    req_q.push_back(r);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        reply_q.push_back(table_access(cur_req));
        gap_left = pick_gap();
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (req_q.size() > 0) begin
          cur_req = req_q.pop_front();
          in_req_type <= cur_req.insert;
          in_coord_x <= cur_req.x;
          in_coord_y <= cur_req.y;
          in_coord_z <= cur_req.z;
          in_object_handle <= cur_req.handle;
          in_handle_ok <= cur_req.ok;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_valid) begin
      if (reply_q.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected reply: status %0d slot %0d handle %h",
                   out_status, out_slot_index, out_slot_handle);
        mismatches++;
      end else begin
        want = reply_q.pop_front();
        if (out_status !== want.status || out_slot_index !== want.index ||
            out_slot_handle !== want.handle) begin
          if (mismatches < 10)
            $display("mismatch: exp status %0d slot %0d handle %h, got %0d %0d %h",
                     want.status, want.index, want.handle,
                     out_status, out_slot_index, out_slot_handle);
          mismatches++;
        end
      end
    end
  end

  initial begin
    req_t r;
    int   pick;
    int   b;
    // empty table, failed handle, extremes, existing key, near misses
    add_req(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
    add_req(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1'b0);
    add_req(1'b1, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 1'b1);
    add_req(1'b1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000, 1'b1);
    add_req(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h1234, 1'b1);
    add_req(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hA5A5, 1'b1);
    add_req(1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000, 1'b0);
    add_req(1'b1, 16'h8000, 16'h8000, 16'h8000, 16'h0000, 1'b0);
    add_req(1'b1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hBEEF, 1'b1);
    add_req(1'b0, 16'h8000, 16'h8000, 16'h7FFF, 16'h0000, 1'b1);
    add_req(1'b0, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 1'b1);
    add_req(1'b0, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 1'b1);
    add_req(1'b0, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 1'b1);
    add_req(1'b1, 16'h7FFF, 16'h8000, 16'h0000, 16'h5A5A, 1'b1);
    add_req(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0);
    add_req(1'b0, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 1'b0);
    add_req(1'b0, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h0000, 1'b1);
    add_req(1'b1, 16'h0001, 16'h0000, 16'h0000, 16'h0001, 1'b0);
    key_pool.push_back(req_q[2]);
    key_pool.push_back(req_q[3]);
    key_pool.push_back(req_q[4]);
    key_pool.push_back(req_q[5]);
    key_pool.push_back(req_q[13]);

    // random: fresh keys, known keys and one-bit neighbours until well past full
    repeat (1880) begin
      pick = $urandom_range(0, 99);
      if (pick < 45 || key_pool.size() == 0) begin
        r.x = rand_coord();
        r.y = rand_coord();
        r.z = rand_coord();
        key_pool.push_back(r);
      end else if (pick < 80) begin
        r = key_pool[$urandom_range(0, key_pool.size() - 1)];
      end else begin
        r = key_pool[$urandom_range(0, key_pool.size() - 1)];
        b = $urandom_range(0, COORD_W - 1);
        case ($urandom_range(0, 2))
          0: r.x[b] = ~r.x[b];
          1: r.y[b] = ~r.y[b];
          default: r.z[b] = ~r.z[b];
        endcase
        key_pool.push_back(r);
      end
      r.insert = ($urandom_range(0, 99) < 65);
      r.ok = ($urandom_range(0, 99) < 85);
      r.handle = HANDLE_W'($urandom);
      req_q.push_back(r);
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    forever begin
      @(posedge clk);
      #1;
      if (req_q.size() == 0 && !start && reply_q.size() == 0) break;
    end
    repeat (300) @(posedge clk);

    if (reply_q.size() != 0)
      $display("%0d replies never arrived", reply_q.size());
    if (mismatches == 0 && reply_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(60_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/cks_pkg.sv
rtl/core/cks_slot_mem.sv
rtl/core/cks_scan_unit.sv
rtl/core/coord_keyed_slot_table_core.sv
rtl/core/cks_checker.sv
test/coord_keyed_slot_table_core_tb.sv
